### rtl/mcvpid_pkg.sv
// ----------------------------------------------------------------------------
// mcvpid_pkg
// Shared widths, reset values, register indexes and types of the
// multi-channel velocity PID.
// ----------------------------------------------------------------------------
package mcvpid_pkg;

	localparam int NUM_CHANNELS_DEF = 4;

	// stream field widths
	localparam int CH_W      = 2;
	localparam int SPEED_W   = 11;
	localparam int DRIVE_W   = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// datapath widths
	localparam int ERR_W    = 12;
	localparam int SUM_W    = 17;
	localparam int DIFF_W   = 13;
	localparam int GAIN_W   = 16;
	localparam int LIM_W    = 15;
	localparam int PROD_P_W = 28;
	localparam int PROD_I_W = 33;
	localparam int PROD_D_W = 29;
	localparam int RAW_W    = 32;

	// largest magnitude the stored error sum can take after clamp and add
	localparam logic signed [SUM_W-1:0] SUM_BOUND = 17'sd34814;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 16'sd3000;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = 16'sd5;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 16'sd20;
	localparam logic        [LIM_W-1:0]  INT_LIMIT_RST = 15'd1000;
	localparam logic        [LIM_W-1:0]  OUT_LIMIT_RST = 15'd3500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_I    = 3'd1,
		CFG_GAIN_D    = 3'd2,
		CFG_INT_LIMIT = 3'd3,
		CFG_OUT_LIMIT = 3'd4
	} cfg_idx_t;

	// per-channel history word
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic signed [ERR_W-1:0] perr;
	} hist_t;

	// gains and drive bound seen by the multiply stage
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic        [LIM_W-1:0]  output_limit;
	} gains_t;

endpackage

### rtl/mcvpid_hist_mem.sv
// ----------------------------------------------------------------------------
// mcvpid_hist_mem
// Per-channel history store: one write port, one read port with registered
// read data, write-first bypass and per-entry valid bits.
// ----------------------------------------------------------------------------
module mcvpid_hist_mem #(
	parameter int NUM_CHANNELS = mcvpid_pkg::NUM_CHANNELS_DEF,
	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output mcvpid_pkg::hist_t  rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  mcvpid_pkg::hist_t  wr_data
);

	mcvpid_pkg::hist_t        mem_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]  vld_q;
	mcvpid_pkg::hist_t        rd_q;
	logic                     rd_vld_q;
	logic                     bypass;

	// a read and a write of the same entry at one edge return the new word
	assign bypass = rd_en && wr_en && (rd_addr == wr_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= bypass ? wr_data : mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr] || bypass;
			end
		end
	end

	// an entry never written reads as zero history
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### rtl/mcvpid_calc.sv
// ----------------------------------------------------------------------------
// mcvpid_calc
// Registered gain products, then three-term sum and symmetric saturation.
// ----------------------------------------------------------------------------
module mcvpid_calc (
	input  logic                                     clk,
	input  logic                                     ld,
	input  logic signed [mcvpid_pkg::ERR_W-1:0]      err,
	input  logic signed [mcvpid_pkg::SUM_W-1:0]      sum,
	input  logic signed [mcvpid_pkg::DIFF_W-1:0]     diff,
	input  mcvpid_pkg::gains_t                       gains,
	output logic signed [mcvpid_pkg::DRIVE_W-1:0]    drive,
	output logic                                     saturated
);

	logic signed [mcvpid_pkg::PROD_P_W-1:0] prod_p_s3;
	logic signed [mcvpid_pkg::PROD_I_W-1:0] prod_i_s3;
	logic signed [mcvpid_pkg::PROD_D_W-1:0] prod_d_s3;
	logic        [mcvpid_pkg::LIM_W-1:0]    out_lim_s3;
	logic signed [mcvpid_pkg::RAW_W-1:0]    raw;
	logic signed [mcvpid_pkg::RAW_W-1:0]    lim_pos;
	logic signed [mcvpid_pkg::RAW_W-1:0]    lim_neg;

	always_ff @(posedge clk) begin
		if (ld) begin
			prod_p_s3  <= mcvpid_pkg::PROD_P_W'(gains.gain_p) * mcvpid_pkg::PROD_P_W'(err);
			prod_i_s3  <= mcvpid_pkg::PROD_I_W'(gains.gain_i) * mcvpid_pkg::PROD_I_W'(sum);
			prod_d_s3  <= mcvpid_pkg::PROD_D_W'(gains.gain_d) * mcvpid_pkg::PROD_D_W'(diff);
			out_lim_s3 <= gains.output_limit;
		end
	end

	always_comb begin
		raw     = mcvpid_pkg::RAW_W'(prod_p_s3) + mcvpid_pkg::RAW_W'(prod_i_s3)
			+ mcvpid_pkg::RAW_W'(prod_d_s3);
		lim_pos = $signed({{(mcvpid_pkg::RAW_W - mcvpid_pkg::LIM_W){1'b0}}, out_lim_s3});
		lim_neg = -lim_pos;
		if (raw > lim_pos) begin
			drive     = mcvpid_pkg::DRIVE_W'(lim_pos);
			saturated = 1'b1;
		end else if (raw < lim_neg) begin
			drive     = mcvpid_pkg::DRIVE_W'(lim_neg);
			saturated = 1'b1;
		end else begin
			drive     = mcvpid_pkg::DRIVE_W'(raw);
			saturated = 1'b0;
		end
	end

endmodule

### rtl/multi_channel_velocity_pid.sv
// ----------------------------------------------------------------------------
// multi_channel_velocity_pid
// Velocity PID for several motor channels sharing one set of integer gains.
// ----------------------------------------------------------------------------
// Takes one sample transaction per clock unless back-pressure stalls the pipe,
// and presents one drive transaction per sample, in order, through the history,
// operand, product and output registers. The per-channel error sum and previous
// error sit in a small synchronous store that is read when a sample is accepted
// and written back as the sample moves on to the operand registers; a
// write-first bypass covers two back-to-back samples of the same channel, so
// the read-modify-write loop sets the one-per-cycle rate. The register stages
// are: history read, clamp and accumulate into the operand registers, three
// gain multiplies, then sum and saturation into the output register.
// Each stage holds only while the stage after it is full, so bubbles close up
// under back-pressure. History entries are marked valid per channel and read
// as zero until first written, so no clearing pass runs after reset. A
// channel at or above NUM_CHANNELS leaves the history untouched and returns a
// drive of zero. Configuration writes take effect on the next cycle and are
// meant to happen only while no sample is in flight.
// ----------------------------------------------------------------------------
module multi_channel_velocity_pid #(
	parameter int NUM_CHANNELS = mcvpid_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [mcvpid_pkg::S_TDATA_W-1:0]       s_tdata,  // channel, target_speed, measured_speed
	input  logic                                   s_tuser,  // clear_history
	// drive stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mcvpid_pkg::M_TDATA_W-1:0]       m_tdata,  // drive, out_channel, zero pad
	output logic                                   m_tuser,  // saturated
	// configuration
	input  logic                                   cfg_we,
	input  logic [mcvpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcvpid_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// configuration registers
	logic signed [mcvpid_pkg::GAIN_W-1:0] gain_p_q;
	logic signed [mcvpid_pkg::GAIN_W-1:0] gain_i_q;
	logic signed [mcvpid_pkg::GAIN_W-1:0] gain_d_q;
	logic        [mcvpid_pkg::LIM_W-1:0]  int_limit_q;
	logic        [mcvpid_pkg::LIM_W-1:0]  out_limit_q;
	mcvpid_pkg::gains_t                   gains;

	// input unpack
	logic        [mcvpid_pkg::CH_W-1:0]    in_channel;
	logic signed [mcvpid_pkg::SPEED_W-1:0] in_target;
	logic signed [mcvpid_pkg::SPEED_W-1:0] in_measured;
	logic signed [mcvpid_pkg::ERR_W-1:0]   in_err;
	logic                                  in_range;
	logic                                  s_accept;

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic ld_s2, ld_s3, ld_out;
	logic free_s2, free_s3;

	// stage 1: history update
	logic        [mcvpid_pkg::CH_W-1:0]  ch_s1;
	logic                                range_s1;
	logic                                clear_s1;
	logic signed [mcvpid_pkg::ERR_W-1:0] err_s1;
	mcvpid_pkg::hist_t                   rd_hist;
	mcvpid_pkg::hist_t                   wr_hist;
	logic                                wr_en;
	logic signed [mcvpid_pkg::SUM_W-1:0] base_sum;
	logic signed [mcvpid_pkg::ERR_W-1:0] base_perr;
	logic signed [mcvpid_pkg::SUM_W-1:0] ilim_pos;
	logic signed [mcvpid_pkg::SUM_W-1:0] clamped_sum;
	logic signed [mcvpid_pkg::SUM_W-1:0] new_sum;
	logic signed [mcvpid_pkg::DIFF_W-1:0] new_diff;

	// stage 2: multiply operands
	logic        [mcvpid_pkg::CH_W-1:0]   ch_s2;
	logic                                 range_s2;
	logic signed [mcvpid_pkg::ERR_W-1:0]  err_s2;
	logic signed [mcvpid_pkg::SUM_W-1:0]  sum_s2;
	logic signed [mcvpid_pkg::DIFF_W-1:0] diff_s2;

	// stage 3: products live in the calc unit
	logic        [mcvpid_pkg::CH_W-1:0]    ch_s3;
	logic                                  range_s3;
	logic signed [mcvpid_pkg::DRIVE_W-1:0] calc_drive;
	logic                                  calc_sat;

	// output register
	logic                                  m_tvalid_q;
	logic signed [mcvpid_pkg::DRIVE_W-1:0] drive_q;
	logic        [mcvpid_pkg::CH_W-1:0]    ch_q;
	logic                                  sat_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= mcvpid_pkg::GAIN_P_RST;
			gain_i_q    <= mcvpid_pkg::GAIN_I_RST;
			gain_d_q    <= mcvpid_pkg::GAIN_D_RST;
			int_limit_q <= mcvpid_pkg::INT_LIMIT_RST;
			out_limit_q <= mcvpid_pkg::OUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (mcvpid_pkg::cfg_idx_t'(cfg_index))
				mcvpid_pkg::CFG_GAIN_P:    gain_p_q    <= cfg_wdata;
				mcvpid_pkg::CFG_GAIN_I:    gain_i_q    <= cfg_wdata;
				mcvpid_pkg::CFG_GAIN_D:    gain_d_q    <= cfg_wdata;
				mcvpid_pkg::CFG_INT_LIMIT: int_limit_q <= cfg_wdata[mcvpid_pkg::LIM_W-1:0];
				mcvpid_pkg::CFG_OUT_LIMIT: out_limit_q <= cfg_wdata[mcvpid_pkg::LIM_W-1:0];
				default: ;  // unmapped index: drop
			endcase
		end
	end

	assign gains = '{gain_p: gain_p_q, gain_i: gain_i_q, gain_d: gain_d_q,
		output_limit: out_limit_q};

	// ------------------------------------------------------------ handshake
	assign ld_out   = v_s3 && (!m_tvalid_q || m_tready);
	assign free_s3  = !v_s3 || ld_out;
	assign ld_s3    = v_s2 && free_s3;
	assign free_s2  = !v_s2 || ld_s3;
	assign ld_s2    = v_s1 && free_s2;
	assign s_tready = !v_s1 || ld_s2;
	assign s_accept = s_tvalid && s_tready;

	assign in_channel  = s_tdata[1:0];
	assign in_target   = s_tdata[12:2];
	assign in_measured = s_tdata[23:13];
	assign in_err      = mcvpid_pkg::ERR_W'(in_target) - mcvpid_pkg::ERR_W'(in_measured);
	assign in_range    = int'(in_channel) < NUM_CHANNELS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (free_s3) begin
				v_s3 <= v_s2;
			end
			if (!m_tvalid_q || m_tready) begin
				m_tvalid_q <= v_s3;
			end
		end
	end

	// --------------------------------------------------------------- stage 1
	always_ff @(posedge clk) begin
		if (s_accept) begin
			ch_s1    <= in_channel;
			range_s1 <= in_range;
			clear_s1 <= s_tuser;
			err_s1   <= in_err;
		end
	end

	mcvpid_hist_mem #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_hist_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept && in_range),
		.rd_addr (AW'(in_channel)),
		.rd_data (rd_hist),
		.wr_en   (wr_en),
		.wr_addr (AW'(ch_s1)),
		.wr_data (wr_hist)
	);

	always_comb begin
		base_sum  = clear_s1 ? '0 : rd_hist.sum;
		base_perr = clear_s1 ? '0 : rd_hist.perr;
		ilim_pos  = $signed({{(mcvpid_pkg::SUM_W - mcvpid_pkg::LIM_W){1'b0}}, int_limit_q});
		if (base_sum > ilim_pos) begin
			clamped_sum = ilim_pos;
		end else if (base_sum < -ilim_pos) begin
			clamped_sum = -ilim_pos;
		end else begin
			clamped_sum = base_sum;
		end
		new_sum  = clamped_sum + mcvpid_pkg::SUM_W'(err_s1);
		new_diff = mcvpid_pkg::DIFF_W'(err_s1) - mcvpid_pkg::DIFF_W'(base_perr);
	end

	// write back as the sample leaves stage 1
	assign wr_en   = ld_s2 && range_s1;
	assign wr_hist = '{sum: new_sum, perr: err_s1};

	// --------------------------------------------------------------- stage 2
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			ch_s2    <= ch_s1;
			range_s2 <= range_s1;
			err_s2   <= err_s1;
			sum_s2   <= new_sum;
			diff_s2  <= new_diff;
		end
	end

	// ---------------------------------------------------------- stages 3, 4
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ch_s3    <= ch_s2;
			range_s3 <= range_s2;
		end
	end

	mcvpid_calc u_calc (
		.clk       (clk),
		.ld        (ld_s3),
		.err       (err_s2),
		.sum       (sum_s2),
		.diff      (diff_s2),
		.gains     (gains),
		.drive     (calc_drive),
		.saturated (calc_sat)
	);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			ch_q    <= ch_s3;
			drive_q <= range_s3 ? calc_drive : '0;
			sat_q   <= range_s3 && calc_sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(mcvpid_pkg::M_TDATA_W - mcvpid_pkg::DRIVE_W - mcvpid_pkg::CH_W){1'b0}},
		ch_q, drive_q};
	assign m_tuser  = sat_q;

	// ------------------------------------------------------------ assertions
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (v_s1 && (int'(ch_s1) < NUM_CHANNELS)))
		else $error("history write for an empty stage or an unmapped channel");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((wr_hist.sum <= mcvpid_pkg::SUM_BOUND)
			&& (wr_hist.sum >= -mcvpid_pkg::SUM_BOUND)))
		else $error("stored error sum outside its clamp bound");

	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !(int'(ch_q) < NUM_CHANNELS)) |-> ((drive_q == '0) && !sat_q))
		else $error("unmapped channel returned a nonzero drive");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && m_tvalid_q && !m_tready) |=> v_s3)
		else $error("stage 3 result lost under back-pressure");

endmodule
